// ===== hw/rtl/ttl_kvc_pkg.sv =====
// ============================================================================
// ttl_kvc_pkg
// Shared types and constants for the key-to-handle cache with time to live.
// ============================================================================
package ttl_kvc_pkg;

	localparam int unsigned CAPACITY_DEF = 256;
	localparam int unsigned KEY_W        = 256;
	localparam int unsigned TIME_W       = 32;
	localparam logic [31:0] TTL_RESET    = 32'd3600;

	// Configuration register byte addresses.
	localparam logic [2:0] ADDR_ENABLE = 3'd0;
	localparam logic [2:0] ADDR_TTL    = 3'd4;

	// Commands.
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_STORE  = 1'b1;

	// Result status codes.
	localparam logic [2:0] ST_HIT            = 3'd0;
	localparam logic [2:0] ST_MISS           = 3'd1;
	localparam logic [2:0] ST_EXPIRED        = 3'd2;
	localparam logic [2:0] ST_UPDATED        = 3'd3;
	localparam logic [2:0] ST_INSERTED       = 3'd4;
	localparam logic [2:0] ST_EVICT_EXPIRED  = 3'd5;
	localparam logic [2:0] ST_EVICT_SMALLEST = 3'd6;
	localparam logic [2:0] ST_DISABLED       = 3'd7;

	typedef struct packed {
		logic        command;
		logic [63:0] key_word0;
		logic [63:0] key_word1;
		logic [63:0] key_word2;
		logic [63:0] key_word3;
		logic [31:0] value_in;
		logic [31:0] current_time;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] value_out;
		logic [2:0]  status;
	} rsp_t;

	// Per-slot record held in the entry memory.
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [31:0]       value;
		logic [TIME_W-1:0] expiry;
		logic [31:0]       stamp;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_WRITE
	} state_t;

endpackage

// ===== hw/rtl/ttl_kvc_ram.sv =====
// ============================================================================
// ttl_kvc_ram
// Generic single-port synchronous RAM with a registered read.
// ============================================================================
module ttl_kvc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read before write: a write cycle returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== hw/rtl/ttl_key_value_cache_top.sv =====
// ============================================================================
// ttl_key_value_cache_top
// Key-to-handle cache with time to live, built around one entry memory.
// ============================================================================
// Usage: raise start with a command beat on req while busy is low. The block
// scans every slot of the entry memory once, one slot per cycle, then answers
// with a single beat on rsp, marked by done for exactly one cycle.
// For both commands, the block steps through the scan of every slot, a drain
// state for the last read data, a decision state and the done state. A store
// writes its slot during the done cycle. busy stays high through the done
// cycle, so the next command is taken in the cycle after done at the earliest;
// commands never overlap, since the entry memory has one read port.
// Configuration goes through the APB port: enable at address 0, ttl_seconds
// at address 4. Writes take effect at once; reads return the registers.
// Reset clears enable, loads ttl_seconds with 3600, clears all slot valid
// bits, the entry count and the insert stamp counter. The memory contents
// need no clearing since only valid slots are ever used.
// The receiver cannot stall; each rsp beat is valid only while done is high.
// ============================================================================
module ttl_key_value_cache_top #(
	parameter int unsigned CAPACITY = ttl_kvc_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ttl_kvc_pkg::req_t  req,
	output logic               busy,
	output logic               done,
	output ttl_kvc_pkg::rsp_t  rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned EW = $bits(ttl_kvc_pkg::entry_t);

	// Configuration registers.
	logic        enable_q;
	logic [31:0] ttl_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			ttl_q    <= ttl_kvc_pkg::TTL_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr == ttl_kvc_pkg::ADDR_ENABLE) begin
				enable_q <= pwdata[0];
			end else if (paddr == ttl_kvc_pkg::ADDR_TTL) begin
				ttl_q <= pwdata;
			end
		end
	end

	always_comb begin
		case (paddr)
			ttl_kvc_pkg::ADDR_ENABLE: prdata = {31'd0, enable_q};
			ttl_kvc_pkg::ADDR_TTL:    prdata = ttl_q;
			default:                  prdata = 32'd0;
		endcase
	end

	// Control and scan state.
	ttl_kvc_pkg::state_t state_q, state_d;
	ttl_kvc_pkg::req_t   req_q;
	logic [CAPACITY-1:0] valid_q;
	logic [CW-1:0]       count_q;
	logic [31:0]         stamp_q;
	logic [AW-1:0]       idx_q;      // address being read
	logic                rd_v_s1;    // read data valid this cycle
	logic [AW-1:0]       rd_idx_s1;  // slot whose data arrives

	// Scan results.
	logic          match_q;
	logic [AW-1:0] match_idx_q;
	logic          exp_found_q;
	logic [AW-1:0] exp_idx_q;
	logic [31:0]   exp_age_q;
	logic          min_found_q;
	logic [AW-1:0] min_idx_q;
	logic [31:0]   min_exp_q;
	logic [31:0]   min_age_q;
	logic          free_found_q;
	logic [AW-1:0] free_idx_q;
	logic [31:0]   hit_value_q;
	logic          hit_live_q;

	// Decision registers for the write step.
	logic [AW-1:0] wr_idx_q;
	logic [31:0]   new_exp_q;
	logic [31:0]   wr_stamp_q;
	logic          write_pending_q;

	// Memory port.
	logic                mem_we;
	logic [AW-1:0]       mem_addr;
	ttl_kvc_pkg::entry_t mem_wdata, mem_rdata;

	ttl_kvc_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_entry_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Expiry on store: now + ttl, saturated.
	logic [32:0] exp_sum;
	assign exp_sum = {1'b0, req_q.current_time} + {1'b0, ttl_q};

	// Per-slot evaluation of the arriving read data.
	logic        cur_valid, cur_match, cur_expired;
	logic [31:0] cur_age;
	assign cur_valid   = rd_v_s1 && valid_q[rd_idx_s1];
	assign cur_match   = cur_valid && (mem_rdata.key == {req_q.key_word3, req_q.key_word2,
		req_q.key_word1, req_q.key_word0});
	assign cur_expired = (mem_rdata.expiry != 32'd0) && (mem_rdata.expiry <= req_q.current_time);
	assign cur_age     = stamp_q - mem_rdata.stamp;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ttl_kvc_pkg::S_IDLE:   if (start) state_d = ttl_kvc_pkg::S_SCAN;
			ttl_kvc_pkg::S_SCAN:   if (idx_q == AW'(CAPACITY - 1)) state_d = ttl_kvc_pkg::S_DRAIN;
			ttl_kvc_pkg::S_DRAIN:  state_d = ttl_kvc_pkg::S_DECIDE;
			ttl_kvc_pkg::S_DECIDE: state_d = ttl_kvc_pkg::S_WRITE;
			ttl_kvc_pkg::S_WRITE:  state_d = ttl_kvc_pkg::S_IDLE;
			default:               state_d = ttl_kvc_pkg::S_IDLE;
		endcase
	end

	assign busy = state_q != ttl_kvc_pkg::S_IDLE;

	// Decision made once the scan is complete.
	logic          do_write, do_evict;
	logic [AW-1:0] evict_idx, ins_idx;
	logic [2:0]    st_d;
	always_comb begin
		do_write  = 1'b0;
		do_evict  = 1'b0;
		evict_idx = exp_found_q ? exp_idx_q : min_idx_q;
		ins_idx   = free_idx_q;
		st_d      = ttl_kvc_pkg::ST_DISABLED;
		if (!enable_q) begin
			st_d = ttl_kvc_pkg::ST_DISABLED;
		end else if (req_q.command == ttl_kvc_pkg::CMD_LOOKUP) begin
			if (!match_q)         st_d = ttl_kvc_pkg::ST_MISS;
			else if (!hit_live_q) st_d = ttl_kvc_pkg::ST_EXPIRED;
			else                  st_d = ttl_kvc_pkg::ST_HIT;
		end else if (match_q) begin
			do_write = 1'b1;
			ins_idx  = match_idx_q;
			st_d     = ttl_kvc_pkg::ST_UPDATED;
		end else if (count_q >= CW'(CAPACITY)) begin
			// Full: the freed slot is the only free one.
			do_write = 1'b1;
			do_evict = 1'b1;
			ins_idx  = evict_idx;
			st_d     = exp_found_q ? ttl_kvc_pkg::ST_EVICT_EXPIRED
				: ttl_kvc_pkg::ST_EVICT_SMALLEST;
		end else begin
			do_write = free_found_q;
			ins_idx  = free_idx_q;
			st_d     = ttl_kvc_pkg::ST_INSERTED;
		end
	end

	// Memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = idx_q;
		mem_wdata = '{key: {req_q.key_word3, req_q.key_word2, req_q.key_word1,
			req_q.key_word0}, value: req_q.value_in, expiry: new_exp_q, stamp: wr_stamp_q};
		if (state_q == ttl_kvc_pkg::S_WRITE) begin
			mem_we   = write_pending_q;
			mem_addr = wr_idx_q;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ttl_kvc_pkg::S_IDLE;
			valid_q         <= '0;
			count_q         <= '0;
			stamp_q         <= '0;
			idx_q           <= '0;
			rd_v_s1         <= 1'b0;
			done            <= 1'b0;
			write_pending_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= 1'b0;
			rd_v_s1 <= state_q == ttl_kvc_pkg::S_SCAN;
			if (state_q == ttl_kvc_pkg::S_IDLE) begin
				idx_q <= '0;
			end else if (state_q == ttl_kvc_pkg::S_SCAN) begin
				idx_q <= idx_q + AW'(1);
			end
			if (state_q == ttl_kvc_pkg::S_DECIDE) begin
				done            <= 1'b1;
				write_pending_q <= do_write;
				if (do_write && !match_q) begin
					valid_q[ins_idx] <= 1'b1;
					stamp_q          <= stamp_q + 32'd1;
					if (!do_evict) count_q <= count_q + CW'(1);
				end
			end
			if (state_q == ttl_kvc_pkg::S_WRITE) begin
				write_pending_q <= 1'b0;
			end
		end
	end

	// Scan accumulators and payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ttl_kvc_pkg::S_IDLE && start) begin
			req_q <= req;
		end
		if (state_q == ttl_kvc_pkg::S_IDLE) begin
			match_q      <= 1'b0;
			exp_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (rd_v_s1) begin
			if (!valid_q[rd_idx_s1]) begin
				if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= rd_idx_s1;
				end
			end else begin
				if (cur_match && !match_q) begin
					match_q     <= 1'b1;
					match_idx_q <= rd_idx_s1;
					hit_live_q  <= !cur_expired;
					hit_value_q <= mem_rdata.value;
					// Keep the old stamp for an in-place update.
					min_age_q   <= mem_rdata.stamp;
				end
				if (cur_expired && (!exp_found_q || cur_age < exp_age_q)) begin
					exp_found_q <= 1'b1;
					exp_idx_q   <= rd_idx_s1;
					exp_age_q   <= cur_age;
				end
			end
		end
		if (state_q == ttl_kvc_pkg::S_DECIDE) begin
			wr_idx_q      <= ins_idx;
			wr_stamp_q    <= match_q ? min_age_q : stamp_q;
			new_exp_q     <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
			rsp.hit       <= st_d == ttl_kvc_pkg::ST_HIT;
			rsp.value_out <= st_d == ttl_kvc_pkg::ST_HIT ? hit_value_q : 32'd0;
			rsp.status    <= st_d;
		end
	end

	// Read address pipeline.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
	end

	// Smallest-expiry search, with the newer entry winning ties.
	logic [31:0] min_age_cand;
	always_ff @(posedge clk) begin
		if (state_q == ttl_kvc_pkg::S_IDLE) begin
			min_found_q <= 1'b0;
			min_exp_q   <= '0;
		end else if (cur_valid && (!min_found_q || mem_rdata.expiry < min_exp_q ||
			(mem_rdata.expiry == min_exp_q && cur_age < min_age_cand))) begin
			min_found_q  <= 1'b1;
			min_idx_q    <= rd_idx_s1;
			min_exp_q    <= mem_rdata.expiry;
			min_age_cand <= cur_age;
		end
	end

endmodule
